>>> rtl/core/q16alu_pkg.sv
// ---------------------------------------------------------------------------
// q16alu_pkg - shared types for the fixed-point ALU core
// Operation codes and the control word that travels along the pipeline.
// ---------------------------------------------------------------------------
package q16alu_pkg;

    // Operation codes carried on the command field
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Per-beat control word handed from stage to stage
    typedef struct packed {
        logic valid;   // stage holds a live beat
        logic is_div;  // beat is a divide, cells build its quotient
        logic neg_q;   // operand signs differ, quotient is negated at the end
        logic dbz;     // divide with zero divisor
    } t_ctl;

endpackage

>>> rtl/core/q16alu_front.sv
// ---------------------------------------------------------------------------
// q16alu_front - operand stage
// Decodes the command, forms add/sub/mul results and prepares the divide
// numerator and divisor magnitudes for the cell chain.
// ---------------------------------------------------------------------------
module q16alu_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_load,
    input  logic [1:0]                     i_command,
    input  logic signed [WORD_BITS-1:0]    i_operand_a,
    input  logic signed [WORD_BITS-1:0]    i_operand_b,
    output q16alu_pkg::t_ctl               o_ctl,
    output logic [WORD_BITS-1:0]           o_res,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_num,
    output logic [WORD_BITS-1:0]           o_div
);

    localparam int PW = 2 * WORD_BITS;
    localparam int NW = WORD_BITS + FRAC_BITS;

    q16alu_pkg::t_op            op;
    logic signed [PW-1:0]       prod;
    logic [WORD_BITS-1:0]       mag_a;
    logic [WORD_BITS-1:0]       mag_b;
    q16alu_pkg::t_ctl           n_ctl;
    logic [WORD_BITS-1:0]       n_res;

    q16alu_pkg::t_ctl           r_ctl;
    logic [WORD_BITS-1:0]       r_res;
    logic [NW-1:0]              r_num;
    logic [WORD_BITS-1:0]       r_div;

    assign op    = q16alu_pkg::t_op'(i_command);
    assign prod  = PW'(i_operand_a) * PW'(i_operand_b);
    assign mag_a = i_operand_a[WORD_BITS-1] ? WORD_BITS'(~i_operand_a) + WORD_BITS'(1)
                                            : WORD_BITS'(i_operand_a);
    assign mag_b = i_operand_b[WORD_BITS-1] ? WORD_BITS'(~i_operand_b) + WORD_BITS'(1)
                                            : WORD_BITS'(i_operand_b);

    // Command decode and the add, subtract and multiply results
    always_comb begin
        n_ctl.valid  = i_load;
        n_ctl.is_div = 1'b0;
        n_ctl.neg_q  = i_operand_a[WORD_BITS-1] ^ i_operand_b[WORD_BITS-1];
        n_ctl.dbz    = 1'b0;
        unique case (op)
            q16alu_pkg::OP_ADD: begin
                n_res = WORD_BITS'(i_operand_a + i_operand_b);
            end
            q16alu_pkg::OP_SUB: begin
                n_res = WORD_BITS'(i_operand_a - i_operand_b);
            end
            q16alu_pkg::OP_MUL: begin
                // arithmetic shift by the fraction bits, wrapped to the word
                n_res = prod[FRAC_BITS +: WORD_BITS];
            end
            q16alu_pkg::OP_DIV: begin
                n_res        = '0;
                n_ctl.is_div = 1'b1;
                n_ctl.dbz    = (i_operand_b == '0);
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
        if (i_en) begin
            r_res <= n_res;
            r_num <= {mag_a, FRAC_BITS'(0)};
            r_div <= mag_b;
        end
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_num = r_num;
    assign o_div = r_div;

endmodule

>>> rtl/core/q16alu_div_cell.sv
// ---------------------------------------------------------------------------
// q16alu_div_cell - one restoring-division step
// Shifts one numerator bit into the partial remainder, trial-subtracts the
// divisor and appends one quotient bit. Non-divide beats pass straight on.
// ---------------------------------------------------------------------------
module q16alu_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  q16alu_pkg::t_ctl               i_ctl,
    input  logic [WORD_BITS-1:0]           i_res,
    input  logic [WORD_BITS-1:0]           i_rem,
    input  logic [WORD_BITS+FRAC_BITS-1:0] i_num,
    input  logic [WORD_BITS-1:0]           i_div,
    output q16alu_pkg::t_ctl               o_ctl,
    output logic [WORD_BITS-1:0]           o_res,
    output logic [WORD_BITS-1:0]           o_rem,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_num,
    output logic [WORD_BITS-1:0]           o_div
);

    localparam int NW = WORD_BITS + FRAC_BITS;

    logic [WORD_BITS:0]   part;
    logic [WORD_BITS:0]   diff;
    logic                 q_bit;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_res;

    q16alu_pkg::t_ctl     r_ctl;
    logic [WORD_BITS-1:0] r_res;
    logic [WORD_BITS-1:0] r_rem;
    logic [NW-1:0]        r_num;
    logic [WORD_BITS-1:0] r_div;

    // Trial subtract; remainder stays below the divisor so fits the word
    assign part  = {i_rem, i_num[NW-1]};
    assign diff  = part - {1'b0, i_div};
    assign q_bit = (part >= {1'b0, i_div});
    assign n_rem = q_bit ? diff[WORD_BITS-1:0] : part[WORD_BITS-1:0];
    // quotient shifts in from the bottom, upper bits drop off (wrap)
    assign n_res = i_ctl.is_div ? {i_res[WORD_BITS-2:0], q_bit} : i_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_res <= n_res;
            r_rem <= n_rem;
            r_num <= {i_num[NW-2:0], 1'b0};
            r_div <= i_div;
        end
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_div = r_div;

endmodule

>>> rtl/core/q16alu_back.sv
// ---------------------------------------------------------------------------
// q16alu_back - result stage
// Applies the quotient sign, forces zero on divide by zero and holds the
// output beat until it is taken.
// ---------------------------------------------------------------------------
module q16alu_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  q16alu_pkg::t_ctl            i_ctl,
    input  logic [WORD_BITS-1:0]        i_res,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic                        o_divide_by_zero
);

    logic [WORD_BITS-1:0] n_value;

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_value;
    logic                 r_dbz;

    // Sign and zero fix-up
    always_comb begin
        if (i_ctl.dbz) begin
            n_value = '0;
        end else if (i_ctl.is_div && i_ctl.neg_q) begin
            n_value = WORD_BITS'(~i_res) + WORD_BITS'(1);
        end else begin
            n_value = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_value <= n_value;
            r_dbz   <= i_ctl.dbz;
        end
    end

    assign o_valid          = r_valid;
    assign o_result_value   = $signed(r_value);
    assign o_divide_by_zero = r_dbz;

endmodule

>>> rtl/core/fixed_point_q16_alu_core.sv
// ---------------------------------------------------------------------------
// fixed_point_q16_alu_core - pipelined signed fixed-point ALU
// Add, subtract, multiply and divide on two's complement fixed-point words.
// ---------------------------------------------------------------------------
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-----------------------------------
//  in      | i_in_valid   | o_in_ready   | i_command, i_operand_a, i_operand_b
//  out     | o_out_valid  | i_out_ready  | o_result_value, o_divide_by_zero
//
//  One beat enters per cycle unless the output is held. A divide chain of
//  one cell per numerator bit lies between the operand and result stages.
//  All commands ride the same chain, so results leave in arrival order.
//  Reset clears only the control words and the output valid flag, not the data.
//  A held output beat freezes the whole chain, and the input with it.
// ---------------------------------------------------------------------------
module fixed_point_q16_alu_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_command,
    input  logic signed [WORD_BITS-1:0] i_operand_a,
    input  logic signed [WORD_BITS-1:0] i_operand_b,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic                        o_divide_by_zero
);

    localparam int NW     = WORD_BITS + FRAC_BITS;
    localparam int NCELLS = NW;

    logic                 en;
    q16alu_pkg::t_ctl     ctl_s [0:NCELLS];
    logic [WORD_BITS-1:0] res_s [0:NCELLS];
    logic [WORD_BITS-1:0] rem_s [0:NCELLS];
    logic [NW-1:0]        num_s [0:NCELLS];
    logic [WORD_BITS-1:0] div_s [0:NCELLS];

    // Chain moves whenever the output slot is free or being emptied
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    q16alu_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_load      (i_in_valid),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_ctl       (ctl_s[0]),
        .o_res       (res_s[0]),
        .o_num       (num_s[0]),
        .o_div       (div_s[0])
    );

    // partial remainder starts empty
    assign rem_s[0] = '0;

    // Divide chain, one quotient bit per cell
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        q16alu_div_cell #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_s[g]),
            .i_res   (res_s[g]),
            .i_rem   (rem_s[g]),
            .i_num   (num_s[g]),
            .i_div   (div_s[g]),
            .o_ctl   (ctl_s[g+1]),
            .o_res   (res_s[g+1]),
            .o_rem   (rem_s[g+1]),
            .o_num   (num_s[g+1]),
            .o_div   (div_s[g+1])
        );
    end

    q16alu_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_ctl            (ctl_s[NCELLS]),
        .i_res            (res_s[NCELLS]),
        .o_valid          (o_out_valid),
        .o_result_value   (o_result_value),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // Checks
    a_dbz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_by_zero |-> o_result_value == '0)
        else $error("divide by zero beat carries a non-zero result");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ctl_s[0].valid)
        else $error("accepted beat missing from operand stage");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(ctl_s[0]) && $stable(ctl_s[NCELLS]))
        else $error("chain moved while output was stalled");

    a_dbz_only_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_s[0].valid && ctl_s[0].dbz |-> ctl_s[0].is_div)
        else $error("divide-by-zero flag on a non-divide beat");

endmodule

>>> bench/fixed_point_q16_alu_core_tb.sv
// ---------------------------------------------------------------------------
// fixed_point_q16_alu_core_tb - self-checking bench for the Q16.16 ALU core
// A directed table of corner cases and then random beats are pushed through
// the pipeline under several idle and stall patterns. Every accepted beat is
// predicted in the bench, and each output beat is checked in order against
// the oldest prediction.
// ---------------------------------------------------------------------------
module fixed_point_q16_alu_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD       = 32;
    localparam int FRAC       = 16;
    localparam int PIPE_DEPTH = WORD + FRAC + 2;
    localparam int HOLD_LEN   = 400;
    localparam int N_DIRECTED = 26;

    // Directed row: operands plus, where obvious, the result typed in
    typedef struct packed {
        q16alu_pkg::t_op  op;
        logic [WORD-1:0]  a;
        logic [WORD-1:0]  b;
        logic             known;
        logic [WORD-1:0]  res;
        logic             dbz;
    } t_row;

    typedef struct {
        logic [WORD-1:0] res;
        logic            dbz;
    } t_alu_out;

    // DUT ports
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_command   = 2'd0;
    logic signed [WORD-1:0] i_operand_a = '0;
    logic signed [WORD-1:0] i_operand_b = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [WORD-1:0] o_result_value;
    logic                   o_divide_by_zero;

    // Typed-in expectation travelling with the payload of a directed beat
    logic            row_known = 1'b0;
    logic [WORD-1:0] row_res   = '0;
    logic            row_dbz   = 1'b0;

    t_alu_out pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_gen       = 0;
    int n_errors       = 0;
    int n_results      = 0;
    int n_dbz          = 0;
    int n_beats        = 0;
    int n_by_op [4]    = '{0, 0, 0, 0};

    // Corner cases: wrap on add/sub, product sign and rounding, divide edges
    t_row dir_tbl [N_DIRECTED] = '{
        '{q16alu_pkg::OP_ADD, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_ADD, 32'h7FFFFFFF, 32'h00000001, 1'b1, 32'h80000000, 1'b0},
        '{q16alu_pkg::OP_ADD, 32'h80000000, 32'h80000000, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_ADD, 32'hFFFFFFFF, 32'h00000001, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_ADD, 32'h12345678, 32'hEDCBA987, 1'b0, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_SUB, 32'h80000000, 32'h00000001, 1'b1, 32'h7FFFFFFF, 1'b0},
        '{q16alu_pkg::OP_SUB, 32'h00000000, 32'h80000000, 1'b1, 32'h80000000, 1'b0},
        '{q16alu_pkg::OP_SUB, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h80000000, 1'b0},
        '{q16alu_pkg::OP_SUB, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'h00010000, 32'h00010000, 1'b1, 32'h00010000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'h00020000, 32'hFFFF0000, 1'b1, 32'hFFFE0000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'h80000000, 32'h80000000, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'h00000001, 32'h00000001, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_MUL, 32'hFFFFFFFF, 32'h00000001, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'h00010000, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
        '{q16alu_pkg::OP_DIV, 32'h80000000, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
        '{q16alu_pkg::OP_DIV, 32'h80000000, 32'hFFFF0000, 1'b1, 32'h80000000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'h80000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'h00030000, 32'h00020000, 1'b1, 32'h00018000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'hFFFD0000, 32'h00020000, 1'b1, 32'hFFFE8000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'h00000001, 32'h00030000, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'hFFFFFFFF, 32'h00030000, 1'b1, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'h7FFFFFFF, 32'h00000001, 1'b0, 32'h00000000, 1'b0},
        '{q16alu_pkg::OP_DIV, 32'h00000000, 32'h7FFFFFFF, 1'b1, 32'h00000000, 1'b0}
    };

    fixed_point_q16_alu_core #(
        .WORD_BITS (WORD),
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_value   (o_result_value),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q16.16 arithmetic on a double-width intermediate, wrapped to one word
    function automatic t_alu_out alu_predict(q16alu_pkg::t_op op,
                                             logic signed [WORD-1:0] a,
                                             logic signed [WORD-1:0] b);
        logic signed [2*WORD-1:0] wa;
        logic signed [2*WORD-1:0] wb;
        logic signed [2*WORD-1:0] wide;
        t_alu_out                 r;
        wa    = a;
        wb    = b;
        wide  = '0;
        r.dbz = 1'b0;
        case (op)
            q16alu_pkg::OP_ADD: wide = wa + wb;
            q16alu_pkg::OP_SUB: wide = wa - wb;
            q16alu_pkg::OP_MUL: wide = (wa * wb) >>> FRAC;
            default: begin
                // signed division truncates toward zero
                if (b == '0) r.dbz = 1'b1;
                else         wide  = (wa <<< FRAC) / wb;
            end
        endcase
        r.res = wide[WORD-1:0];
        return r;
    endfunction

    // Operand mix: full range, small values, whole numbers, extremes
    function automatic logic [WORD-1:0] rand_operand();
        logic [WORD-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5: begin
                v = $urandom_range(32'h0008_0000);
                if ($urandom_range(1)) v = -v;
            end
            6: v = {16'($urandom_range(16'hFFFF)), 16'h0000};
            7: v = $urandom_range(16'hFFFF) - 32'sd32768;
            default: begin
                case ($urandom_range(5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0001_0000;
                    default: v = 32'hFFFF_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one beat and hold it until accepted; valid stays up on return
    task automatic send_beat(q16alu_pkg::t_op op, logic [WORD-1:0] a,
                             logic [WORD-1:0] b, logic known,
                             logic [WORD-1:0] res, logic dbz);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        row_known   <= known;
        row_res     <= res;
        row_dbz     <= dbz;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // Random beats, occasionally with a zero divisor
    task automatic send_random(int count);
        q16alu_pkg::t_op op;
        logic [WORD-1:0] a;
        logic [WORD-1:0] b;
        repeat (count) begin
            op = q16alu_pkg::t_op'($urandom_range(3));
            a  = rand_operand();
            b  = rand_operand();
            if (op == q16alu_pkg::OP_DIV && $urandom_range(15) == 0) b = '0;
            send_beat(op, a, b, 1'b0, '0, 1'b0);
        end
    endtask

    // Pause the sender until every outstanding result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the monitor record the last accepted beat first
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Input monitor: record the expectation of each accepted beat
    always @(posedge i_clk) begin
        t_alu_out exp_out;
        if (i_rst_n && i_in_valid && o_in_ready === 1'b1) begin
            if (row_known) begin
                exp_out.res = row_res;
                exp_out.dbz = row_dbz;
            end else begin
                exp_out = alu_predict(q16alu_pkg::t_op'(i_command),
                                      i_operand_a, i_operand_b);
            end
            pending_results.push_back(exp_out);
            n_by_op[i_command]++;
            n_beats++;
        end
    end

    // Output side: check each beat, then pick next cycle's ready
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int hold_seen = 0;
        t_alu_out  exp_out;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            n_results++;
            if (o_divide_by_zero === 1'b1) n_dbz++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected beat, actual result %h dbz %b",
                         $time, o_result_value, o_divide_by_zero);
                n_errors++;
            end else begin
                exp_out = pending_results.pop_front();
                if (o_result_value !== exp_out.res) begin
                    $display("%0t ns: result mismatch, expected %h actual %h",
                             $time, exp_out.res, o_result_value);
                    n_errors++;
                end
                if (o_divide_by_zero !== exp_out.dbz) begin
                    $display("%0t ns: dbz mismatch, expected %b actual %b",
                             $time, exp_out.dbz, o_divide_by_zero);
                    n_errors++;
                end
            end
        end
        // long hold-off requested by the stimulus process
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_LEN;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_tbl[i])
            send_beat(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b,
                      dir_tbl[i].known, dir_tbl[i].res, dir_tbl[i].dbz);
        drain_results();

        // idle patterns: none, sender, receiver, both
        send_idle_pct = 0;  recv_stall_pct = 0;
        send_random(350);
        drain_results();
        send_idle_pct = 73; recv_stall_pct = 0;
        send_random(350);
        drain_results();
        send_idle_pct = 0;  recv_stall_pct = 73;
        send_random(350);
        drain_results();
        send_idle_pct = 11; recv_stall_pct = 11;
        send_random(350);
        drain_results();

        // output held for a long stretch while input keeps coming
        send_idle_pct = 0;  recv_stall_pct = 0;
        hold_gen++;
        send_random(150);
        drain_results();

        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("Covered %0d beats: add %0d, sub %0d, mul %0d, div %0d; %0d results",
                 n_beats, n_by_op[q16alu_pkg::OP_ADD], n_by_op[q16alu_pkg::OP_SUB],
                 n_by_op[q16alu_pkg::OP_MUL], n_by_op[q16alu_pkg::OP_DIV],
                 n_results);
        $display("%0d divide-by-zero beats, idle/stall mixes and a long output hold",
                 n_dbz);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("** fixed_point_q16_alu_core: PASSED **");
        end else begin
            $display("** fixed_point_q16_alu_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("** fixed_point_q16_alu_core: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/q16alu_pkg.sv
rtl/core/q16alu_front.sv
rtl/core/q16alu_div_cell.sv
rtl/core/q16alu_back.sv
rtl/core/fixed_point_q16_alu_core.sv
bench/fixed_point_q16_alu_core_tb.sv
